// File: sv/bounded_array_list_engine_top_defines.svh
// Assertion macros for the bounded array list engine.
// Depends on signals named clock and reset in the module that expands them.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_TOP_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BALE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define BALE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/bale_pkg.sv
// Shared types and constants for the bounded array list engine.
// No dependencies.
`default_nettype none
package bale_pkg;

   localparam int BALE_CAPACITY = 256;
   localparam int WORD_W        = 32;
   localparam int OP_W          = 3;
   localparam int IDX_W         = 8;
   localparam int ST_W          = 2;
   localparam int CNT_OUT_W     = 9;

   typedef enum logic [OP_W-1:0] {
      OP_READ   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_APPEND = 3'd2,
      OP_REMOVE = 3'd3,
      OP_INSERT = 3'd4,
      OP_SWAP   = 3'd5
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } st_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_SHIFT,
      S_INS_WR,
      S_SWAP_A,
      S_SWAP_B,
      S_SWAP_C
   } state_type;

   // Index and fill checks on the held item, against the current count.
   typedef struct packed {
      logic ia_ok;
      logic ib_ok;
      logic same;
      logic full;
      logic empty;
   } chk_type;

endpackage
`default_nettype wire

// File: sv/bounded_array_list_engine_top.sv
// A read passes through S_EXEC and S_READ; write, append, remove and refused items
// through S_EXEC alone; swap through S_EXEC and S_SWAP_A to S_SWAP_C; insert at index
// i runs the one-word-a-cycle shift loop in S_SHIFT from the top down to i, over the
// single read and single write port of the element store, then writes it in S_INS_WR.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset clears the count and the sequencer; store contents are left as they are.
`default_nettype none
module bounded_array_list_engine_top
   import bale_pkg::*;
#(
   parameter int CAPACITY = BALE_CAPACITY
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [OP_W-1:0]      req_opcode,
   input  wire logic [IDX_W-1:0]     req_index_a,
   input  wire logic [IDX_W-1:0]     req_index_b,
   input  wire logic [WORD_W-1:0]    req_value,
   output logic                      rsp_valid,
   output logic      [WORD_W-1:0]    rsp_read_value,
   output logic      [ST_W-1:0]      rsp_status,
   output logic      [CNT_OUT_W-1:0] rsp_element_count
);

`include "bounded_array_list_engine_top_defines.svh"

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   // held copy of the accepted item; the sequencer works from these
   logic [OP_W-1:0]   opcode_ff;
   logic [IDX_W-1:0]  index_a_ff;
   logic [IDX_W-1:0]  index_b_ff;
   logic [WORD_W-1:0] value_ff;

   logic              accept;
   chk_type           chk;
   logic [CNT_W-1:0]  count;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   st_type            status;

   assign accept = start && !busy;

   // capture the item at the accept edge; hold it until the next one
   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff  <= req_opcode;
         index_a_ff <= req_index_a;
         index_b_ff <= req_index_b;
         value_ff   <= req_value;
      end
   end

   // index and fill checks against the count the item sees
   always_comb begin
      chk.ia_ok = (CMP_W'(index_a_ff) < CMP_W'(count));
      chk.ib_ok = (CMP_W'(index_b_ff) < CMP_W'(count));
      chk.same  = (index_a_ff == index_b_ff);
      chk.full  = (count == CNT_W'(CAPACITY));
      chk.empty = (count == '0);
   end

   bale_ctrl #(
      .CAPACITY (CAPACITY),
      .ADDR_W   (ADDR_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .opcode     (opcode_ff),
      .index_a    (index_a_ff),
      .index_b    (index_b_ff),
      .value      (value_ff),
      .chk        (chk),
      .rd_data    (rd_data),
      .busy       (busy),
      .count      (count),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rsp_valid  (rsp_valid),
      .rsp_status (status),
      .rsp_data   (rsp_read_value)
   );

   bale_store #(
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // report the count after the operation, modulo 512
   assign rsp_status        = status;
   assign rsp_element_count = CNT_OUT_W'(count);

   `BALE_ASSERT_NEXT(a_busy_after_accept, accept, busy, "busy low after item accepted")
   `BALE_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid, "result strobe held two cycles")
   `BALE_ASSERT_SAME(a_strobe_idle, rsp_valid, !busy, "result strobe while still busy")
   `BALE_ASSERT_SAME(a_empty_count, rsp_valid && (status == ST_EMPTY), count == '0,
      "empty status with elements held")

endmodule
`default_nettype wire

// File: sv/bale_store.sv
// Element store: one write port, one read port with registered read data.
// Depends on bale_pkg for the word width.
`default_nettype none
module bale_store
   import bale_pkg::*;
#(
   parameter int DEPTH  = BALE_CAPACITY,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: sv/bale_ctrl.sv
// Sequencer for the list operations, with the pointer decrementer
// that walks the insert shift. Depends on bale_pkg.
`default_nettype none
module bale_ctrl
   import bale_pkg::*;
#(
   parameter int CAPACITY = BALE_CAPACITY,
   parameter int ADDR_W   = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [OP_W-1:0]   opcode,
   input  wire logic [IDX_W-1:0]  index_a,
   input  wire logic [IDX_W-1:0]  index_b,
   input  wire logic [WORD_W-1:0] value,
   input  wire chk_type           chk,
   input  wire logic [WORD_W-1:0] rd_data,
   output logic                   busy,
   output logic      [CNT_W-1:0]  count,
   output logic                   wr_en,
   output logic      [ADDR_W-1:0] wr_addr,
   output logic      [WORD_W-1:0] wr_data,
   output logic                   rd_en,
   output logic      [ADDR_W-1:0] rd_addr,
   output logic                   rsp_valid,
   output st_type                 rsp_status,
   output logic      [WORD_W-1:0] rsp_data
);

   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [WORD_W-1:0] hold_ff, hold_in;
   logic              rsp_valid_ff, rsp_valid_in;
   st_type            rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]  ptr_dec;
   logic [CNT_W-1:0]  count_m1;
   logic              ptr_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      hold_ff       <= hold_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // pointer decrementer: steps the shift pointer down one place a cycle
   assign ptr_dec  = ptr_ff - CNT_W'(1);
   assign count_m1 = count_ff - CNT_W'(1);
   assign ptr_last = (CMP_W'(ptr_dec) == CMP_W'(index_a));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = ADDR_W'(index_a);
      wr_data       = value;
      rd_en         = 1'b0;
      rd_addr       = ADDR_W'(index_a);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_data_in   = '0;
            rsp_status_in = ST_OK;
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            case (op_type'(opcode))
               OP_READ: begin
                  if (chk.ia_ok) begin
                     rd_en        = 1'b1;
                     state_in     = S_READ;
                     rsp_valid_in = 1'b0;
                  end else begin
                     rsp_status_in = ST_BAD_INDEX;
                  end
               end
               OP_WRITE: begin
                  if (chk.ia_ok) begin
                     wr_en = 1'b1;
                  end else begin
                     rsp_status_in = ST_BAD_INDEX;
                  end
               end
               OP_APPEND: begin
                  if (chk.full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = ADDR_W'(count_ff);
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               OP_REMOVE: begin
                  if (chk.empty) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     count_in = count_m1;
                  end
               end
               OP_INSERT: begin
                  if (chk.full) begin
                     rsp_status_in = ST_FULL;
                  end else if (chk.ia_ok) begin
                     ptr_in       = count_ff;
                     rd_en        = 1'b1;
                     rd_addr      = ADDR_W'(count_m1);
                     state_in     = S_SHIFT;
                     rsp_valid_in = 1'b0;
                  end else begin
                     rsp_status_in = ST_BAD_INDEX;
                  end
               end
               OP_SWAP: begin
                  if (chk.ia_ok && chk.ib_ok && !chk.same) begin
                     rd_en        = 1'b1;
                     state_in     = S_SWAP_A;
                     rsp_valid_in = 1'b0;
                  end else begin
                     rsp_status_in = ST_BAD_INDEX;
                  end
               end
               default: begin
                  rsp_status_in = ST_BAD_INDEX;
               end
            endcase
         end
         S_READ: begin
            rsp_data_in  = rd_data;
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         S_SHIFT: begin
            // move the word read last cycle up one place, fetch the next
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(ptr_ff);
            wr_data = rd_data;
            ptr_in  = ptr_dec;
            if (ptr_last) begin
               state_in = S_INS_WR;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(ptr_dec - CNT_W'(1));
            end
         end
         S_INS_WR: begin
            wr_en        = 1'b1;
            count_in     = count_ff + CNT_W'(1);
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         S_SWAP_A: begin
            hold_in  = rd_data;
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(index_b);
            state_in = S_SWAP_B;
         end
         S_SWAP_B: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            state_in = S_SWAP_C;
         end
         S_SWAP_C: begin
            wr_en        = 1'b1;
            wr_addr      = ADDR_W'(index_b);
            wr_data      = hold_ff;
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign count      = count_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire
